// ===== src/swifr_pkg.sv =====
// Shared types and constants for the stop-and-wait information frame receiver.
package swifr_pkg;

  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned CntW       = $clog2(MaxPayload + 6);
  localparam int unsigned LenW       = 11;

  localparam logic [CntW-1:0] CntPayloadEnd = CntW'(MaxPayload + 4);
  localparam logic [CntW-1:0] CntSat        = CntW'(MaxPayload + 5);
  localparam logic [LenW-1:0] LenMax        = LenW'(MaxPayload);

  localparam logic [7:0] FlagByte  = 8'h7e;
  localparam logic [7:0] EscByte   = 8'h7d;
  localparam logic [7:0] EscFlag   = 8'h5e;
  localparam logic [7:0] EscEsc    = 8'h5d;
  localparam logic [7:0] AddrReset = 8'h03;
  localparam logic [6:0] RrLow     = 7'h05;
  localparam logic [6:0] RejLow    = 7'h01;

  typedef enum logic [2:0] {
    VerdictAccepted  = 3'd0,
    VerdictBcc2Err   = 3'd1,
    VerdictDuplicate = 3'd2,
    VerdictHeaderErr = 3'd3,
    VerdictWrongSeq  = 3'd4,
    VerdictTooLong   = 3'd5
  } verdict_e;

  typedef enum logic {
    KindData    = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    verdict_e        verdict;
    logic            rvalid;
    logic [7:0]      rctl;
    logic [LenW-1:0] len;
  } result_t;

endpackage

// ===== src/swifr_parser.sv =====
// Frame parser: destuffing, header check, payload release and end-of-frame verdict.
module swifr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       expected_address_i,
  output logic             emit_o,
  output swifr_pkg::result_t res_o
);
  import swifr_pkg::*;

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      addr_q, addr_d;
  logic [7:0]      ctl_q, ctl_d;
  logic [7:0]      held_q, held_d;
  logic [7:0]      xor_q, xor_d;
  logic            seq_q, seq_d;
  logic            hok_q, hok_d;

  logic            take;
  logic [7:0]      take_byte;
  logic [7:0]      ctl_now, ctl_prev;
  logic [LenW-1:0] len;

  assign ctl_now  = {1'b0, seq_q, 6'b0};
  assign ctl_prev = {1'b0, ~seq_q, 6'b0};
  // count stops at CntSat, so only that value overruns the length cap
  assign len = (cnt_q == CntSat) ? LenMax : LenW'(cnt_q - CntW'(4));

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    addr_d     = addr_q;
    ctl_d      = ctl_q;
    held_d     = held_q;
    xor_d      = xor_q;
    seq_d      = seq_q;
    hok_d      = hok_q;
    take       = 1'b0;
    take_byte  = rx_byte_i;
    emit_o     = 1'b0;
    res_o      = '{kind: KindData, data: 8'h00, verdict: VerdictAccepted,
                   rvalid: 1'b0, rctl: 8'h00, len: '0};

    if (!in_frame_q) begin
      if (rx_byte_i == FlagByte) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        cnt_d      = '0;
        xor_d      = 8'h00;
        held_d     = 8'h00;
        hok_d      = 1'b0;
      end
    end else if (rx_byte_i == FlagByte) begin
      esc_d = 1'b0;
      if (cnt_q != '0) begin
        in_frame_d     = 1'b0;
        emit_o         = 1'b1;
        res_o.kind     = KindVerdict;
        if (cnt_q < CntW'(4)) begin
          res_o.verdict = VerdictHeaderErr;
        end else begin
          res_o.len = len;
          priority if (!hok_q || addr_q != expected_address_i) begin
            res_o.verdict = VerdictHeaderErr;
          end else if (cnt_q == CntSat) begin
            res_o.verdict = VerdictTooLong;
          end else if (ctl_q == ctl_prev) begin
            res_o.verdict = VerdictDuplicate;
            res_o.rvalid  = 1'b1;
            res_o.rctl    = {seq_q, RrLow};
          end else if (ctl_q != ctl_now) begin
            res_o.verdict = VerdictWrongSeq;
          end else if (xor_q != held_q) begin
            res_o.verdict = VerdictBcc2Err;
            res_o.rvalid  = 1'b1;
            res_o.rctl    = {seq_q, RejLow};
          end else begin
            seq_d         = ~seq_q;
            res_o.verdict = VerdictAccepted;
            res_o.rvalid  = 1'b1;
            res_o.rctl    = {~seq_q, RrLow};
          end
        end
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (rx_byte_i == EscFlag) begin
        take      = 1'b1;
        take_byte = FlagByte;
      end else if (rx_byte_i == EscEsc) begin
        take      = 1'b1;
        take_byte = EscByte;
      end
    end else if (rx_byte_i == EscByte) begin
      esc_d = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take && cnt_q != CntSat) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(0)) begin
        addr_d = take_byte;
      end else if (cnt_q == CntW'(1)) begin
        ctl_d = take_byte;
      end else if (cnt_q == CntW'(2)) begin
        hok_d = (take_byte == (addr_q ^ ctl_q));
      end else begin
        // the held byte is payload once another content byte follows it
        if (cnt_q >= CntW'(4) && cnt_q < CntPayloadEnd) begin
          xor_d = xor_q ^ held_q;
          if (ctl_q == ctl_now) begin
            emit_o     = 1'b1;
            res_o.data = held_q;
          end
        end
        held_d = take_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      cnt_q      <= '0;
      addr_q     <= 8'h00;
      ctl_q      <= 8'h00;
      held_q     <= 8'h00;
      xor_q      <= 8'h00;
      seq_q      <= 1'b0;
      hok_q      <= 1'b0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      cnt_q      <= cnt_d;
      addr_q     <= addr_d;
      ctl_q      <= ctl_d;
      held_q     <= held_d;
      xor_q      <= xor_d;
      seq_q      <= seq_d;
      hok_q      <= hok_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntSat)
    else $error("content count past saturation");
  a_esc_only_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !in_frame_q |=> !esc_q)
    else $error("escape pending outside a frame");
  a_seq_toggle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o && res_o.kind == KindVerdict && res_o.verdict == VerdictAccepted
    |=> seq_q != $past(seq_q))
    else $error("sequence bit did not toggle on acceptance");
`endif

endmodule

// ===== src/stop_wait_info_frame_receiver.sv =====
// Top level: input register, parser, result register and address register.
//
// Usage:
//   Input channel: rx_byte_i with in_valid_i / in_ready_o carries one raw line
//   byte per item. Output channel: out_valid_o / out_ready_i carries one result
//   item: a payload byte (result_kind_o = 0) or an end-of-frame verdict with
//   reply control byte and payload length (result_kind_o = 1).
//   Configuration: cfg_we_i writes cfg_wdata_i into the expected address
//   register in the cycle it is high; write only while the block is idle.
//   Order: an accepted byte waits in the input register, is parsed by the
//   parser, and its result, if any, is then captured in the result register.
//   Throughput: one byte per cycle while results are taken, set by the single
//   parse stage between the input register and the result register.
//   Reset: the block hunts for an opening flag, the sequence bit is 0 and the
//   expected address is 0x03.
//   Stall: while a result waits on out_ready_i, the input register holds one
//   more byte, then in_ready_o drops until the result is taken.
module stop_wait_info_frame_receiver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  input  logic                      cfg_we_i,
  input  logic [7:0]                cfg_wdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [7:0]                data_byte_o,
  output logic [2:0]                verdict_o,
  output logic                      reply_valid_o,
  output logic [7:0]                reply_control_o,
  output logic [swifr_pkg::LenW-1:0] payload_length_o
);
  import swifr_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic [7:0] addr_q;
  logic       step;
  logic       emit;
  result_t    res;

  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  swifr_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .rx_byte_i          (s1_byte_q),
    .expected_address_i (addr_q),
    .emit_o             (emit),
    .res_o              (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      addr_q      <= AddrReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
    if (step && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign data_byte_o      = out_q.data;
  assign verdict_o        = out_q.verdict;
  assign reply_valid_o    = out_q.rvalid;
  assign reply_control_o  = out_q.rctl;
  assign payload_length_o = out_q.len;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");
  a_data_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindData
    |-> verdict_o == VerdictAccepted && !reply_valid_o && payload_length_o == '0)
    else $error("payload item carries verdict fields");
  a_reply_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_valid_o
    |-> reply_control_o[6:0] == RrLow || reply_control_o[6:0] == RejLow)
    else $error("reply control byte is neither RR nor REJ");
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> payload_length_o <= LenMax)
    else $error("payload length above maximum");
`endif

endmodule
